// ===== rtl/core/dsp_pkg.sv =====
// Shared types, constants and codes for the distributed select participant.
// No dependencies; every other file in rtl/core imports this package.
package dsp_pkg;

  // Store geometry
  localparam int CAPACITY = 8;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // Field widths
  localparam int DATA_W    = 32;
  localparam int ACT_W     = 3;
  localparam int DRAW_W    = 16;
  localparam int BIT_W     = $clog2(DRAW_W);
  localparam int KIND_W    = 2;
  localparam int OUT_CNT_W = 4;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_LOAD       = 3'd0;
  localparam logic [ACT_W-1:0] ACT_REQUEST    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_PIVOT      = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DROP_SMALL = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DROP_LARGE = 3'd4;

  // Reply kinds
  localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_COUNT  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READY  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_REJECT = 2'd3;

  // Sample value reported for an empty window
  localparam logic signed [DATA_W-1:0] SAMPLE_NONE = -32'sd1;

  typedef struct packed {
    logic [ACT_W-1:0]         action;
    logic signed [DATA_W-1:0] value;
    logic [DRAW_W-1:0]        random_draw;
  } req_t;

  typedef struct packed {
    logic [KIND_W-1:0]        reply_kind;
    logic signed [DATA_W-1:0] sample_value;
    logic [OUT_CNT_W-1:0]     above_count;
    logic                     window_empty;
    logic [OUT_CNT_W-1:0]     window_size;
  } rsp_t;

  // Flags and difference from the shared subtractor
  typedef struct packed {
    logic              lt;
    logic              eq;
    logic [DATA_W-1:0] diff;
  } alu_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_SCAN,
    ST_MOD,
    ST_SAMPLE,
    ST_DSMALL,
    ST_DLARGE,
    ST_REPLY
  } state_t;

endpackage

// ===== rtl/core/dsp_alu.sv =====
// Shared signed subtract/compare unit used by the insertion, scan, remainder and drop steps.
// Depends on dsp_pkg.
module dsp_alu import dsp_pkg::*; (
  input  logic signed [DATA_W-1:0] a,
  input  logic signed [DATA_W-1:0] b,
  output alu_res_t                 res
);

  logic signed [DATA_W:0] diff;

  // One extra bit keeps the sign of a - b exact over the full range
  assign diff     = {a[DATA_W-1], a} - {b[DATA_W-1], b};
  assign res.lt   = diff[DATA_W];
  assign res.eq   = (diff == '0);
  assign res.diff = diff[DATA_W-1:0];

endmodule

// ===== rtl/core/distributed_select_participant.sv =====
// Top level of the distributed select participant: sequencer, store, reply register.
// Depends on dsp_pkg and dsp_alu.
//
// One participant of a distributed quickselect. Items are taken one at a time; req_stall is
// high while an item is being worked on. A load is accepted and then moves entries up one
// per cycle during sorted insertion before writing the new value. For a sample request the
// remainder of random_draw by the window size is formed one bit per cycle on the shared
// subtractor, then the entry is read and the reply registered. A pivot count walks the
// window one entry per cycle, and each drop walks entries off the window edge one per cycle.
// A reject or an empty-window sample goes straight to the reply. Every compare against a
// stored or pivot value, and every remainder subtract, goes through one shared unit. Replies
// sit in an output register, so a new item can be accepted while a reply waits.
module distributed_select_participant import dsp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  state_t state, state_next;

  logic [CNT_W-1:0]         loaded_count, loaded_count_next;
  logic [CNT_W-1:0]         win_start, win_start_next;
  logic [CNT_W-1:0]         win_end, win_end_next;
  logic signed [DATA_W-1:0] last_pivot, last_pivot_next;

  logic signed [DATA_W-1:0] val, val_next;
  logic [DRAW_W-1:0]        draw, draw_next;
  logic [CNT_W-1:0]         idx, idx_next;
  logic [CNT_W-1:0]         above, above_next;
  logic [CNT_W-1:0]         rem, rem_next;
  logic [BIT_W-1:0]         bit_cnt, bit_cnt_next;
  logic                     empty, empty_next;
  rsp_t                     res, res_next;
  rsp_t                     rsp_next;
  logic                     rsp_valid_next;

  logic signed [DATA_W-1:0] store [CAPACITY];
  logic                     store_we;
  logic [IDX_W-1:0]         store_widx;
  logic signed [DATA_W-1:0] store_wdata;
  logic [IDX_W-1:0]         rd_idx;
  logic signed [DATA_W-1:0] rd_data;

  logic signed [DATA_W-1:0] alu_a, alu_b;
  alu_res_t                 alu;
  logic                     alu_gt;

  logic [CNT_W-1:0]         clamp_end, clamp_start, size, idx_m1, end_m1, pos;
  logic [CNT_W:0]           r2;

  dsp_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .res (alu)
  );

  assign alu_gt    = !alu.lt && !alu.eq;
  assign rd_data   = store[rd_idx];
  assign req_stall = (state != ST_IDLE);

  // Window bounds kept inside the loaded entries
  assign clamp_end   = (win_end > loaded_count) ? loaded_count : win_end;
  assign clamp_start = (win_start > clamp_end) ? clamp_end : win_start;
  assign size        = win_end - win_start;
  assign idx_m1      = idx - 1'b1;
  assign end_m1      = win_end - 1'b1;
  assign pos         = win_start + rem;
  assign r2          = {rem, draw[DRAW_W-1]};

  // Sequencer: next state, datapath updates and shared-unit operands
  always_comb begin
    state_next        = state;
    loaded_count_next = loaded_count;
    win_start_next    = win_start;
    win_end_next      = win_end;
    last_pivot_next   = last_pivot;
    val_next          = val;
    draw_next         = draw;
    idx_next          = idx;
    above_next        = above;
    rem_next          = rem;
    bit_cnt_next      = bit_cnt;
    empty_next        = empty;
    res_next          = res;
    rsp_next          = rsp;
    rsp_valid_next    = rsp_valid && rsp_stall;
    store_we          = 1'b0;
    store_widx        = idx[IDX_W-1:0];
    store_wdata       = val;
    rd_idx            = idx[IDX_W-1:0];
    alu_a             = rd_data;
    alu_b             = val;

    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          win_end_next   = clamp_end;
          win_start_next = clamp_start;
          unique case (req.action)
            ACT_LOAD: begin
              if (loaded_count >= CNT_W'(CAPACITY)) begin
                res_next   = '{KIND_REJECT, '0, '0, 1'b0, '0};
                state_next = ST_REPLY;
              end else begin
                idx_next   = loaded_count;
                val_next   = req.value;
                state_next = ST_SHIFT;
              end
            end
            ACT_REQUEST: begin
              if (clamp_start == clamp_end) begin
                res_next   = '{KIND_SAMPLE, SAMPLE_NONE, '0, 1'b1, '0};
                state_next = ST_REPLY;
              end else begin
                rem_next     = '0;
                draw_next    = req.random_draw;
                bit_cnt_next = '0;
                state_next   = ST_MOD;
              end
            end
            ACT_PIVOT: begin
              last_pivot_next = req.value;
              val_next        = req.value;
              idx_next        = clamp_start;
              above_next      = '0;
              empty_next      = (clamp_start == clamp_end);
              state_next      = ST_SCAN;
            end
            ACT_DROP_SMALL: state_next = ST_DSMALL;
            ACT_DROP_LARGE: state_next = ST_DLARGE;
            default:        state_next = ST_IDLE;
          endcase
        end
      end

      // Sorted insertion, one entry moved per cycle
      ST_SHIFT: begin
        rd_idx = idx_m1[IDX_W-1:0];
        store_we = 1'b1;
        if ((idx != '0) && alu_gt) begin
          store_wdata = rd_data;
          idx_next    = idx_m1;
        end else begin
          store_wdata       = val;
          loaded_count_next = loaded_count + 1'b1;
          win_start_next    = '0;
          win_end_next      = loaded_count + 1'b1;
          state_next        = ST_IDLE;
        end
      end

      // Count window entries above the pivot
      ST_SCAN: begin
        if (idx < win_end) begin
          if (alu_gt) begin
            above_next = above + 1'b1;
          end
          idx_next = idx + 1'b1;
        end else begin
          res_next   = '{KIND_COUNT, '0, OUT_CNT_W'(above), empty, '0};
          state_next = ST_REPLY;
        end
      end

      // Restoring remainder of the draw by the window size, one bit per cycle
      ST_MOD: begin
        alu_a        = DATA_W'(r2);
        alu_b        = DATA_W'(size);
        rem_next     = alu.lt ? r2[CNT_W-1:0] : alu.diff[CNT_W-1:0];
        draw_next    = draw << 1;
        bit_cnt_next = bit_cnt + 1'b1;
        if (bit_cnt == BIT_W'(DRAW_W - 1)) begin
          state_next = ST_SAMPLE;
        end
      end

      ST_SAMPLE: begin
        rd_idx     = pos[IDX_W-1:0];
        res_next   = '{KIND_SAMPLE, rd_data, '0, 1'b0, '0};
        state_next = ST_REPLY;
      end

      // Move the window start past entries below the pivot
      ST_DSMALL: begin
        rd_idx = win_start[IDX_W-1:0];
        alu_b  = last_pivot;
        if ((win_start < win_end) && alu.lt) begin
          win_start_next = win_start + 1'b1;
        end else begin
          res_next   = '{KIND_READY, '0, '0, 1'b0, '0};
          state_next = ST_REPLY;
        end
      end

      // Move the window end below entries above the pivot
      ST_DLARGE: begin
        rd_idx = end_m1[IDX_W-1:0];
        alu_b  = last_pivot;
        if ((win_end > win_start) && alu_gt) begin
          win_end_next = end_m1;
        end else begin
          res_next   = '{KIND_READY, '0, '0, 1'b0, '0};
          state_next = ST_REPLY;
        end
      end

      // Hand the reply to the output register once it is free
      ST_REPLY: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_next             = res;
          rsp_next.window_size = OUT_CNT_W'(size);
          rsp_valid_next       = 1'b1;
          state_next           = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      loaded_count <= '0;
      win_start    <= '0;
      win_end      <= '0;
      last_pivot   <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      loaded_count <= loaded_count_next;
      win_start    <= win_start_next;
      win_end      <= win_end_next;
      last_pivot   <= last_pivot_next;
      rsp_valid    <= rsp_valid_next;
    end
  end

  // Working registers and reply payload
  always_ff @(posedge clk) begin
    val     <= val_next;
    draw    <= draw_next;
    idx     <= idx_next;
    above   <= above_next;
    rem     <= rem_next;
    bit_cnt <= bit_cnt_next;
    empty   <= empty_next;
    res     <= res_next;
    rsp     <= rsp_next;
  end

  // Sorted store
  always_ff @(posedge clk) begin
    if (store_we) begin
      store[store_widx] <= store_wdata;
    end
  end

`ifndef SYNTHESIS
  a_window_order: assert property (@(posedge clk) disable iff (rst)
    (win_start <= win_end) && (win_end <= loaded_count))
    else $error("window bounds out of order");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    loaded_count <= CNT_W'(CAPACITY))
    else $error("loaded count beyond capacity");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MOD) |-> (rem < size))
    else $error("remainder not below window size");

  a_reply_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REPLY) && rsp_valid && rsp_stall |=> (state == ST_REPLY))
    else $error("reply dropped while output register busy");
`endif

endmodule
